// ===== sv/wcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcc_pkg
// Shared types and constants of the windowed co-occurrence counter.
// ----------------------------------------------------------------------------
package wcc_pkg;

    // default sizes
    localparam int DEF_VOCAB_SIZE  = 1024;
    localparam int DEF_MAX_BUCKETS = 64;
    localparam int DEF_MAX_WINDOW  = 8;
    localparam int DEF_COUNT_WIDTH = 32;

    // fixed field widths
    localparam int WORD_W   = 10;
    localparam int HASH_W   = 32;
    localparam int RBKT_W   = 6;
    localparam int BUCKET_W = 7;
    localparam int WIN_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // register reset values
    localparam logic [WIN_W-1:0]    WINDOW_RST  = 4'd5;
    localparam logic [BUCKET_W-1:0] BUCKETS_RST = 7'd64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKETS = 1'b1;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // hash reduction: bits retired per cycle and step count
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = HASH_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // classified command handed from front to back
    typedef struct packed {
        logic                is_read;
        logic                sent_start;
        logic                row_ok;
        logic                rd_err;
        logic [WORD_W-1:0]   word;
        logic [BUCKET_W-1:0] bucket;
    } t_op;

endpackage

// ===== sv/wcc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcc_front
// Takes commands, reduces the hash of a push modulo the bucket count and
// classifies range errors, then hands the command to the queue.
// ----------------------------------------------------------------------------
module wcc_front
    import wcc_pkg::*;
#(
    parameter int VOCAB_SIZE = DEF_VOCAB_SIZE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_cmd,
    input  logic                i_sentence_start,
    input  logic [WORD_W-1:0]   i_word_id,
    input  logic [HASH_W-1:0]   i_word_hash,
    input  logic [RBKT_W-1:0]   i_read_bucket,
    input  logic [BUCKET_W-1:0] i_nb,
    input  logic                i_q_full,
    output logic                o_busy,
    output logic                o_q_push,
    output t_op                 o_q_op
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_step;
    logic [HASH_W-1:0]    r_dividend;
    logic [BUCKET_W-1:0]  r_rem;
    logic [BUCKET_W-1:0]  n_rem;
    t_op                  r_op;
    logic                 w_row_ok;

    assign w_row_ok = (32'(i_word_id) < VOCAB_SIZE);

    // restoring remainder, several hash bits per cycle
    always_comb begin
        logic [BUCKET_W:0] v_part;
        n_rem = r_rem;
        for (int k = 0; k < DIV_BITS; k++) begin
            v_part = {n_rem, r_dividend[HASH_W-1-k]};
            if (v_part >= {1'b0, i_nb}) begin
                v_part = v_part - {1'b0, i_nb};
            end
            n_rem = v_part[BUCKET_W-1:0];
        end
    end

    // state transitions
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_accept) begin
                    n_state = (i_cmd == CMD_READ) ? F_PUSH : F_DIV;
                end
            end
            F_DIV: begin
                if (r_step == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_accept) begin
            r_op.is_read    <= (i_cmd == CMD_READ);
            r_op.sent_start <= i_sentence_start;
            r_op.row_ok     <= w_row_ok;
            r_op.rd_err     <= !w_row_ok || ({1'b0, i_read_bucket} >= i_nb);
            r_op.word       <= i_word_id;
            r_op.bucket     <= {1'b0, i_read_bucket};
            r_dividend      <= i_word_hash;
            r_rem           <= '0;
            r_step          <= '0;
        end else if (r_state == F_DIV) begin
            r_dividend <= r_dividend << DIV_BITS;
            r_rem      <= n_rem;
            r_step     <= r_step + 1'b1;
            if (r_step == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_op.bucket <= n_rem;
            end
        end
    end

    assign o_busy   = (r_state != F_IDLE);
    assign o_q_push = (r_state == F_PUSH) && !i_q_full;
    assign o_q_op   = r_op;

endmodule

// ===== sv/wcc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcc_queue
// Short first-in first-out queue of classified commands.
// ----------------------------------------------------------------------------
module wcc_queue
    import wcc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_op  o_op
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_op              r_slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_op    = r_slots[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slots[r_wr_ptr] <= i_op;
        end
    end

endmodule

// ===== sv/wcc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcc_back
// Keeps the token ring and the counter memory: clears the memory after
// reset, does the read-modify-write of each context pair and answers reads.
// ----------------------------------------------------------------------------
module wcc_back
    import wcc_pkg::*;
#(
    parameter int VOCAB_SIZE  = DEF_VOCAB_SIZE,
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [WIN_W-1:0]   i_context_window,
    input  logic               i_q_empty,
    input  t_op                i_q_op,
    output logic               o_q_pop,
    output logic               o_clearing,
    output logic               o_strobe,
    output logic [VALUE_W-1:0] o_count_value,
    output logic               o_index_error
);

    localparam int DEPTH  = VOCAB_SIZE * MAX_BUCKETS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int HEAD_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_PAIR_A = 3'd2;
    localparam logic [2:0] S_A_WR   = 3'd3;
    localparam logic [2:0] S_PAIR_B = 3'd4;
    localparam logic [2:0] S_B_WR   = 3'd5;
    localparam logic [2:0] S_RWAIT  = 3'd6;

    logic [2:0]             r_state, n_state;
    logic [ADDR_W-1:0]      r_clr_addr;
    t_op                    r_op;
    logic [HEAD_W-1:0]      r_head;
    logic [FILL_W-1:0]      r_fill;
    logic [HEAD_W-1:0]      r_ptr;
    logic [FILL_W-1:0]      r_left;
    logic [ADDR_W-1:0]      r_rmw_addr;
    logic [WORD_W-1:0]      r_ring_word [MAX_WINDOW];
    logic [BUCKET_W-1:0]    r_ring_bkt  [MAX_WINDOW];
    logic [COUNT_WIDTH-1:0] r_mem [DEPTH];
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_strobe;
    logic [VALUE_W-1:0]     r_value;
    logic                   r_err;

    logic                   w_pop;
    logic [FILL_W-1:0]      w_win;
    logic [FILL_W-1:0]      w_fill_eff;
    logic [HEAD_W-1:0]      w_head_eff;
    logic [WORD_W-1:0]      w_old_word;
    logic [BUCKET_W-1:0]    w_old_bkt;
    logic                   w_old_row_ok;
    logic [ADDR_W-1:0]      w_addr_a;
    logic [ADDR_W-1:0]      w_addr_b;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;
    logic [COUNT_WIDTH-1:0] w_bumped;

    function automatic logic [HEAD_W-1:0] prev_slot(input logic [HEAD_W-1:0] p);
        return (p == '0) ? HEAD_W'(MAX_WINDOW - 1) : p - 1'b1;
    endfunction

    function automatic logic [HEAD_W-1:0] next_slot(input logic [HEAD_W-1:0] p);
        return (p == HEAD_W'(MAX_WINDOW - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [WORD_W-1:0] row,
                                                    input logic [BUCKET_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(MAX_BUCKETS) + ADDR_W'(col);
    endfunction

    // effective window and ring view after a sentence start
    assign w_win = (32'(i_context_window) > MAX_WINDOW) ? FILL_W'(MAX_WINDOW)
                                                       : FILL_W'(i_context_window);
    assign w_fill_eff = i_q_op.sent_start ? '0 : r_fill;
    assign w_head_eff = i_q_op.sent_start ? '0 : r_head;

    // remembered token under the pair pointer
    assign w_old_word   = r_ring_word[r_ptr];
    assign w_old_bkt    = r_ring_bkt[r_ptr];
    assign w_old_row_ok = (32'(w_old_word) < VOCAB_SIZE);
    assign w_addr_a     = cell_addr(r_op.word, w_old_bkt);
    assign w_addr_b     = cell_addr(w_old_word, r_op.bucket);
    assign w_bumped     = (&r_rd_data) ? r_rd_data : r_rd_data + 1'b1;

    assign w_pop = (r_state == S_IDLE) && !i_q_empty;

    // state transitions and memory control
    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_rmw_addr;
        mem_wdata = w_bumped;
        mem_re    = 1'b0;
        mem_raddr = w_addr_a;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_pop) begin
                    if (i_q_op.is_read) begin
                        if (!i_q_op.rd_err) begin
                            mem_re    = 1'b1;
                            mem_raddr = cell_addr(i_q_op.word, i_q_op.bucket);
                            n_state   = S_RWAIT;
                        end
                    end else begin
                        n_state = S_PAIR_A;
                    end
                end
            end
            S_PAIR_A: begin
                if (r_left == '0) begin
                    n_state = S_IDLE;
                end else if (r_op.row_ok) begin
                    mem_re  = 1'b1;
                    n_state = S_A_WR;
                end else begin
                    n_state = S_PAIR_B;
                end
            end
            S_A_WR: begin
                mem_we  = 1'b1;
                n_state = S_PAIR_B;
            end
            S_PAIR_B: begin
                mem_raddr = w_addr_b;
                if (w_old_row_ok) begin
                    mem_re  = 1'b1;
                    n_state = S_B_WR;
                end else begin
                    n_state = S_PAIR_A;
                end
            end
            S_B_WR: begin
                mem_we  = 1'b1;
                n_state = S_PAIR_A;
            end
            S_RWAIT: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_head     <= '0;
            r_fill     <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (w_pop && i_q_op.is_read && i_q_op.rd_err) || (r_state == S_RWAIT);
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_pop && !i_q_op.is_read) begin
                r_head <= w_head_eff;
                r_fill <= w_fill_eff;
            end
            // ring entry goes in once all pairs are done
            if (r_state == S_PAIR_A && r_left == '0) begin
                r_head <= next_slot(r_head);
                if (r_fill != FILL_W'(MAX_WINDOW)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    // pair walk and results
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_op   <= i_q_op;
            r_ptr  <= prev_slot(w_head_eff);
            r_left <= (w_fill_eff < w_win) ? w_fill_eff : w_win;
            r_value <= '0;
            r_err   <= 1'b1;
        end
        if (r_state == S_PAIR_A) begin
            r_rmw_addr <= w_addr_a;
        end
        if (r_state == S_PAIR_B) begin
            r_rmw_addr <= w_addr_b;
        end
        if ((r_state == S_PAIR_B && !w_old_row_ok) || r_state == S_B_WR) begin
            r_ptr  <= prev_slot(r_ptr);
            r_left <= r_left - 1'b1;
        end
        if (r_state == S_RWAIT) begin
            r_value <= VALUE_W'(r_rd_data);
            r_err   <= 1'b0;
        end
    end

    // token ring
    always_ff @(posedge i_clk) begin
        if (r_state == S_PAIR_A && r_left == '0) begin
            r_ring_word[r_head] <= r_op.word;
            r_ring_bkt[r_head]  <= r_op.bucket;
        end
    end

    // counter memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    assign o_q_pop       = w_pop;
    assign o_clearing    = (r_state == S_CLEAR);
    assign o_strobe      = r_strobe;
    assign o_count_value = r_value;
    assign o_index_error = r_err;

endmodule

// ===== sv/windowed_cooccurrence_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_cooccurrence_counter
// Windowed word/context co-occurrence counter with hashed context buckets.
// ----------------------------------------------------------------------------
// After reset the counter memory is cleared one entry a cycle, all
// VOCAB_SIZE * MAX_BUCKETS entries (65536 by default), with busy high
// throughout; configuration writes are taken during that time. A command
// is taken when start is high and busy is low. The front holds busy while
// it works on a command: on a push it reduces the hash 4 bits a cycle, and
// it stays busy longer while the queue is full; a two-entry queue then lets
// it take the next command while the back works. On a push the back walks
// the context pairs; for each pair it reads and writes the counter memory
// once for each of the two counters, one after the other. A read result
// leaves the back through a register, and a valid read also goes through
// the memory read register and a wait state first. The result is shown on
// o_strobe for exactly one cycle; it cannot be held off and must be taken
// then. Results come in command order.
// ----------------------------------------------------------------------------
module windowed_cooccurrence_counter
    import wcc_pkg::*;
#(
    parameter int VOCAB_SIZE  = DEF_VOCAB_SIZE,
    parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cmd,
    input  logic                  i_sentence_start,
    input  logic [WORD_W-1:0]     i_word_id,
    input  logic [HASH_W-1:0]     i_word_hash,
    input  logic [RBKT_W-1:0]     i_read_bucket,
    output logic                  o_strobe,
    output logic [VALUE_W-1:0]    o_count_value,
    output logic                  o_index_error
);

    logic [WIN_W-1:0]    r_context_window;
    logic [BUCKET_W-1:0] r_bucket_count;
    logic [BUCKET_W-1:0] w_nb;
    logic                w_accept;
    logic                w_front_busy;
    logic                w_clearing;
    logic                w_q_push;
    logic                w_q_pop;
    logic                w_q_full;
    logic                w_q_empty;
    t_op                 w_front_op;
    t_op                 w_back_op;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_context_window <= WINDOW_RST;
            r_bucket_count   <= BUCKETS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WINDOW:  r_context_window <= i_cfg_data[WIN_W-1:0];
                CFG_BUCKETS: r_bucket_count   <= i_cfg_data[BUCKET_W-1:0];
                default: ;
            endcase
        end
    end

    // effective bucket count, zero acts as one
    assign w_nb = (r_bucket_count == '0) ? BUCKET_W'(1)
                : (32'(r_bucket_count) > MAX_BUCKETS) ? BUCKET_W'(MAX_BUCKETS)
                : r_bucket_count;

    assign busy     = w_front_busy || w_clearing;
    assign w_accept = start && !busy;

    wcc_front #(
        .VOCAB_SIZE (VOCAB_SIZE)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_cmd            (i_cmd),
        .i_sentence_start (i_sentence_start),
        .i_word_id        (i_word_id),
        .i_word_hash      (i_word_hash),
        .i_read_bucket    (i_read_bucket),
        .i_nb             (w_nb),
        .i_q_full         (w_q_full),
        .o_busy           (w_front_busy),
        .o_q_push         (w_q_push),
        .o_q_op           (w_front_op)
    );

    wcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_op    (w_front_op),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_op    (w_back_op)
    );

    wcc_back #(
        .VOCAB_SIZE  (VOCAB_SIZE),
        .MAX_BUCKETS (MAX_BUCKETS),
        .MAX_WINDOW  (MAX_WINDOW),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_context_window (r_context_window),
        .i_q_empty        (w_q_empty),
        .i_q_op           (w_back_op),
        .o_q_pop          (w_q_pop),
        .o_clearing       (w_clearing),
        .o_strobe         (o_strobe),
        .o_count_value    (o_count_value),
        .o_index_error    (o_index_error)
    );

`ifndef SYNTHESIS
    // the front only hands over a command when the queue has room
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("command pushed into a full queue");

    // no result while the counter memory is being cleared
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !w_clearing)
        else $error("result during clearing pass");

    // an out-of-range read reports zero
    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_index_error) |-> (o_count_value == '0))
        else $error("index error with nonzero value");

    // a taken command keeps busy high on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("busy low right after a command");
`endif

endmodule

// ===== verif/tb_windowed_cooccurrence_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_cooccurrence_counter
// Self-checking bench for the windowed co-occurrence counter. Push and read
// commands go to the block through start/busy. A behavioral copy of the
// counter store and of the token ring predicts each read, and every strobed
// result is checked against it. The run steps through several window and
// bucket settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_windowed_cooccurrence_counter;
    import wcc_pkg::*;

    localparam int VOCAB      = DEF_VOCAB_SIZE;
    localparam int NBKT       = DEF_MAX_BUCKETS;
    localparam int NWIN       = DEF_MAX_WINDOW;
    // back end can still hold a push in progress and two queued ones
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic              cmd;
        logic              sent_start;
        logic [WORD_W-1:0] word;
        logic [HASH_W-1:0] hash;
        logic [RBKT_W-1:0] rbkt;
    } t_cmd_item;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               err;
    } t_read_result;

    // dut signals, the inputs all known from time zero
    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data       = '0;
    logic                  start            = 1'b0;
    logic                  busy;
    logic                  i_cmd            = CMD_PUSH;
    logic                  i_sentence_start = 1'b0;
    logic [WORD_W-1:0]     i_word_id        = '0;
    logic [HASH_W-1:0]     i_word_hash      = '0;
    logic [RBKT_W-1:0]     i_read_bucket    = '0;
    logic                  o_strobe;
    logic [VALUE_W-1:0]    o_count_value;
    logic                  o_index_error;

    // predicted state of the block
    bit [VALUE_W-1:0]  pair_counts [VOCAB*NBKT];
    bit [WORD_W-1:0]   ring_words   [NWIN];
    bit [BUCKET_W-1:0] ring_buckets [NWIN];
    int unsigned       ring_head = 0;
    int unsigned       ring_fill = 0;
    bit [WIN_W-1:0]    cfg_window  = WINDOW_RST;
    bit [BUCKET_W-1:0] cfg_buckets = BUCKETS_RST;

    t_cmd_item    pending_cmds[$];
    t_read_result expected_reads[$];
    int           fail_count = 0;
    bit           no_idle    = 1'b0;

    // driver and monitor working variables
    t_cmd_item    cur_item;
    int           idle_left = 0;
    bit           has_read;
    t_read_result read_pred;
    t_read_result read_want;

    windowed_cooccurrence_counter uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_sentence_start (i_sentence_start),
        .i_word_id        (i_word_id),
        .i_word_hash      (i_word_hash),
        .i_read_bucket    (i_read_bucket),
        .o_strobe         (o_strobe),
        .o_count_value    (o_count_value),
        .o_index_error    (o_index_error)
    );

    always #5 i_clk = ~i_clk;

    // saturating increment of one word/bucket counter
    function automatic void bump_pair_count(input int unsigned row, input int unsigned col);
        int unsigned addr;
        if (row < VOCAB && col < NBKT) begin
            addr = row * NBKT + col;
            if (pair_counts[addr] != '1)
                pair_counts[addr] = pair_counts[addr] + 1'b1;
        end
    endfunction

    // apply one transaction to the predicted state, return the read result if any
    function automatic void cooc_apply(input t_cmd_item it, output bit got_read,
                                       output t_read_result res);
        int unsigned nb, win, n, slot, bkt;
        nb  = (cfg_buckets == '0) ? 1
            : (32'(cfg_buckets) > NBKT) ? NBKT : 32'(cfg_buckets);
        win = (32'(cfg_window) > NWIN) ? NWIN : 32'(cfg_window);
        res = '0;
        got_read = 1'b0;
        if (it.cmd == CMD_READ) begin
            got_read = 1'b1;
            if (32'(it.rbkt) >= nb || 32'(it.word) >= VOCAB) begin
                res.err = 1'b1;
            end else begin
                res.value = pair_counts[32'(it.word) * NBKT + 32'(it.rbkt)];
            end
        end else begin
            bkt = it.hash % nb;
            if (it.sent_start) begin
                ring_fill = 0;
                ring_head = 0;
            end
            n = (ring_fill < win) ? ring_fill : win;
            // pair the new token with the most recent ones, both directions
            for (int i = 1; i <= n; i++) begin
                slot = (ring_head + NWIN - i) % NWIN;
                bump_pair_count(32'(it.word), 32'(ring_buckets[slot]));
                bump_pair_count(32'(ring_words[slot]), bkt);
            end
            ring_words[ring_head]   = it.word;
            ring_buckets[ring_head] = BUCKET_W'(bkt);
            ring_head = (ring_head + 1) % NWIN;
            if (ring_fill < NWIN)
                ring_fill++;
        end
    endfunction

    // driver: present queued commands with random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            idle_left = 0;
        end else begin
            if (start && !busy) begin
                cooc_apply(cur_item, has_read, read_pred);
                if (has_read)
                    expected_reads.push_back(read_pred);
                idle_left = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (start && busy) begin
                // transaction still waiting, hold everything
            end else if (idle_left > 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                cur_item = pending_cmds.pop_front();
                start            <= 1'b1;
                i_cmd            <= cur_item.cmd;
                i_sentence_start <= cur_item.sent_start;
                i_word_id        <= cur_item.word;
                i_word_hash      <= cur_item.hash;
                i_read_bucket    <= cur_item.rbkt;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check each strobed result against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_reads.size() == 0) begin
                $error("unexpected result: count_value %0d index_error %0b",
                       o_count_value, o_index_error);
                fail_count++;
            end else begin
                read_want = expected_reads.pop_front();
                if (o_count_value !== read_want.value) begin
                    $error("count_value: expected %0d, got %0d",
                           read_want.value, o_count_value);
                    fail_count++;
                end
                if (o_index_error !== read_want.err) begin
                    $error("index_error: expected %0b, got %0b",
                           read_want.err, o_index_error);
                    fail_count++;
                end
            end
        end
    end

    function automatic int unsigned rand_word();
        // mostly a few hot words so that reads hit nonzero counters
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, VOCAB - 1);
        return $urandom_range(0, 15);
    endfunction

    task automatic queue_push(input int unsigned ss, input int unsigned w,
                              input int unsigned h);
        t_cmd_item it;
        it.cmd        = CMD_PUSH;
        it.sent_start = ss[0];
        it.word       = w[WORD_W-1:0];
        it.hash       = h;
        it.rbkt       = RBKT_W'($urandom);
        pending_cmds.push_back(it);
    endtask

    task automatic queue_read(input int unsigned w, input int unsigned b);
        t_cmd_item it;
        it.cmd        = CMD_READ;
        it.sent_start = 1'($urandom);
        it.word       = w[WORD_W-1:0];
        it.hash       = $urandom;
        it.rbkt       = b[RBKT_W-1:0];
        pending_cmds.push_back(it);
    endtask

    // mostly whole sentences with reads mixed in, a little noise
    task automatic queue_random(input int n_items);
        int made, len, roll;
        made = 0;
        while (made < n_items) begin
            roll = $urandom_range(0, 9);
            if (roll <= 5) begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++) begin
                    queue_push((k == 0) ? 1 : 0, rand_word(), $urandom);
                    made++;
                    if ($urandom_range(0, 4) == 0) begin
                        queue_read(rand_word(), $urandom_range(0, NBKT - 1));
                        made++;
                    end
                end
            end else if (roll <= 8) begin
                queue_read(rand_word(), $urandom_range(0, NBKT - 1));
                made++;
            end else begin
                queue_push($urandom, $urandom_range(0, VOCAB - 1), $urandom);
                made++;
            end
        end
    endtask

    task automatic wait_quiet();
        while (pending_cmds.size() != 0 || start || busy || expected_reads.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write both registers; upper data bits of the window write are don't-care
    task automatic set_regs(input int unsigned win, input int unsigned nbk);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        data[WIN_W-1:0] = WIN_W'(win);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_WINDOW;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_index <= CFG_BUCKETS;
        i_cfg_data  <= CFG_DATA_W'(nbk);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_window  = WIN_W'(win);
        cfg_buckets = BUCKET_W'(nbk);
    endtask

    // stimulus and end of run
    initial begin
        int unsigned win_set [8];
        int unsigned bkt_set [8];
        win_set = '{1, 8, 15, 0, 3, 2, 0, 0};
        bkt_set = '{1, 64, 127, 0, 7, 33, 0, 0};
        win_set[6] = $urandom_range(0, 15);
        bkt_set[6] = $urandom_range(0, 127);
        win_set[7] = $urandom_range(0, 15);
        bkt_set[7] = $urandom_range(0, 127);

        // directed part at reset settings: fresh reads, ring wrap, restarts
        queue_read(0, 0);
        queue_read(VOCAB - 1, NBKT - 1);
        queue_push(1, 0, 32'h0000_0000);
        queue_push(0, VOCAB - 1, 32'hFFFF_FFFF);
        queue_push(0, VOCAB - 1, 32'h8000_003F);
        for (int k = 2; k < 8; k++)
            queue_push(0, k, 32'h0123_4567 * k);
        queue_push(0, 0, 32'd64);
        queue_push(0, 5, 32'h7FFF_FFFF);
        queue_push(1, 9, 32'd1);
        queue_push(0, 9, 32'd1);
        queue_read(0, NBKT - 1);
        queue_read(VOCAB - 1, NBKT - 1);
        queue_read(0, 0);
        queue_read(9, 1);
        queue_read(VOCAB - 1, 0);
        queue_read(5, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_random(90);
        wait_quiet();
        for (int p = 0; p < 8; p++) begin
            set_regs(win_set[p], bkt_set[p]);
            no_idle = (p % 3 == 1);
            queue_random(90);
            wait_quiet();
        end

        if (expected_reads.size() != 0)
            $error("%0d reads never returned", expected_reads.size());
        if (fail_count == 0 && expected_reads.size() == 0) begin
            $display("tb_windowed_cooccurrence_counter: PASS");
        end else begin
            $display("tb_windowed_cooccurrence_counter: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("tb_windowed_cooccurrence_counter: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/wcc_pkg.sv
sv/wcc_front.sv
sv/wcc_queue.sv
sv/wcc_back.sv
sv/windowed_cooccurrence_counter.sv
verif/tb_windowed_cooccurrence_counter.sv
